### hw/rtl/bsm_pkg.sv
`default_nettype none
package bsm_pkg;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int ROM_OFF_W = 23;
  localparam int ROM_SZ_W  = 24;
  localparam int RAM_SZ_W  = 18;
  localparam int RAM_OFF_W = 17;
  localparam int ROM_BANK_W = 9;
  localparam int RAM_BANK_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_RUMBLE = 2'd2;

  localparam logic [ROM_SZ_W-1:0]   ROM_SIZE_RST = 24'd32768;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RST = 9'd1;
  localparam logic [3:0]            RAM_EN_KEY   = 4'hA;
  localparam logic [DATA_W-1:0]     OPEN_BUS     = 8'hFF;

  // RAM port request
  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [RAM_OFF_W-1:0] addr;
    logic [DATA_W-1:0]    wdata;
  } mem_req_t;

  // decoded item headed for the result stage
  typedef struct packed {
    logic                 rd_ram;
    logic                 rom_fetch;
    logic [ROM_OFF_W-1:0] rom_offset;
    logic                 rumble;
  } stage_t;

endpackage
`default_nettype wire

### hw/rtl/bsm_in_if.sv
`default_nettype none
interface bsm_in_if import bsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] value;

  modport source (output valid, op, address, value, input ready);
  modport sink   (input valid, op, address, value, output ready);
endinterface
`default_nettype wire

### hw/rtl/bsm_out_if.sv
`default_nettype none
interface bsm_out_if import bsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    read_data;
  logic                 rom_fetch;
  logic [ROM_OFF_W-1:0] rom_offset;
  logic                 rumble_on;

  modport source (output valid, read_data, rom_fetch, rom_offset, rumble_on, input ready);
  modport sink   (input valid, read_data, rom_fetch, rom_offset, rumble_on, output ready);
endinterface
`default_nettype wire

### hw/rtl/bsm_cfg_if.sv
`default_nettype none
interface bsm_cfg_if import bsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/bsm_ctrl.sv
`default_nettype none
module bsm_ctrl import bsm_pkg::*; #(
  parameter int RAM_BYTES = 131072
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  bsm_cfg_if.sink                cfg,
  input  wire logic              in_acc,
  input  wire logic              op,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [DATA_W-1:0] value,
  output mem_req_t               req,
  output stage_t                 res
);

  logic [ROM_SZ_W-1:0]   rom_size_r;
  logic [RAM_SZ_W-1:0]   ram_size_r;
  logic                  has_rumble_r;
  logic                  ram_enable_r, ram_enable_nxt;
  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  rumble_r, rumble_nxt;

  logic                 is_wr;
  logic                 in_ram_win;
  logic [RAM_SZ_W-1:0]  ram_lim;
  logic [RAM_OFF_W-1:0] ram_off;
  logic                 ram_ok;
  logic [ROM_OFF_W-1:0] rom_off;
  logic                 rom_ok;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_size_r   <= ROM_SIZE_RST;
      ram_size_r   <= '0;
      has_rumble_r <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ROM_SIZE:   rom_size_r   <= cfg.data;
        CFG_RAM_SIZE:   ram_size_r   <= cfg.data[RAM_SZ_W-1:0];
        CFG_HAS_RUMBLE: has_rumble_r <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign is_wr      = (op == OP_WRITE);
  assign in_ram_win = (address[15:13] == 3'b101);
  assign ram_lim    = (ram_size_r < RAM_SZ_W'(RAM_BYTES)) ? ram_size_r : RAM_SZ_W'(RAM_BYTES);
  assign ram_off    = {ram_bank_r, address[12:0]};
  assign ram_ok     = in_ram_win && ram_enable_r && (RAM_SZ_W'(ram_off) < ram_lim);
  assign rom_off    = address[14] ? {rom_bank_r, address[13:0]} : ROM_OFF_W'(address);
  assign rom_ok     = !address[15] && (ROM_SZ_W'(rom_off) < rom_size_r);

  // mapper register writes
  always_comb begin
    ram_enable_nxt = ram_enable_r;
    rom_bank_nxt   = rom_bank_r;
    ram_bank_nxt   = ram_bank_r;
    rumble_nxt     = rumble_r;
    if (is_wr) begin
      if (address[15:13] == 3'b000) begin
        ram_enable_nxt = (value[3:0] == RAM_EN_KEY);
      end else if (address[15:12] == 4'h2) begin
        rom_bank_nxt = {rom_bank_r[8], value};
      end else if (address[15:12] == 4'h3) begin
        rom_bank_nxt = {value[0], rom_bank_r[7:0]};
      end else if (address[15:13] == 3'b010) begin
        if (has_rumble_r) begin
          rumble_nxt   = value[3];
          ram_bank_nxt = {1'b0, value[2:0]};
        end else begin
          ram_bank_nxt = value[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      rom_bank_r   <= ROM_BANK_RST;
      ram_bank_r   <= '0;
      rumble_r     <= 1'b0;
    end else if (in_acc) begin
      ram_enable_r <= ram_enable_nxt;
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      rumble_r     <= rumble_nxt;
    end
  end

  always_comb begin
    req.we    = in_acc && is_wr && ram_ok;
    req.re    = in_acc && !is_wr && ram_ok;
    req.addr  = ram_off;
    req.wdata = value;

    res.rd_ram     = !is_wr && ram_ok;
    res.rom_fetch  = !is_wr && rom_ok;
    res.rom_offset = (!is_wr && rom_ok) ? rom_off : '0;
    res.rumble     = rumble_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/bsm_ram.sv
`default_nettype none
module bsm_ram import bsm_pkg::*; #(
  parameter int RAM_BYTES = 131072
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mem_req_t     req,
  output logic              busy,
  output logic [DATA_W-1:0] rdata
);

  localparam int AW = $clog2(RAM_BYTES);

  logic [DATA_W-1:0] mem [RAM_BYTES];
  logic [DATA_W-1:0] rdata_r;
  logic              busy_r, busy_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  // zero sweep after reset, one entry per cycle
  always_comb begin
    busy_nxt     = busy_r;
    clr_addr_nxt = clr_addr_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(RAM_BYTES - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign we = busy_r || req.we;
  assign wa = busy_r ? clr_addr_r : req.addr[AW-1:0];
  assign wd = busy_r ? '0 : req.wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign busy  = busy_r;
  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hw/rtl/bank_switch_mapper_9bit_rom_core.sv
//  channel | dir | handshake         | word
//  --------+-----+-------------------+-------------------------------------------
//  in_ch   | in  | valid/ready       | op, address, value
//  out_ch  | out | valid/ready       | read_data, rom_fetch, rom_offset, rumble_on
//  cfg_ch  | in  | valid/ready       | index, data (ready held high)
//
//  One word in per cycle when not stalled by the sweep or the output; each result
//  passes through the decode/RAM access stage, then the output register.
//  Throughput is set by the single RAM port: every word uses at most one access.
//  After reset the RAM is swept to zero; in_ch.ready is low during the sweep,
//  config writes are taken as usual.
//  A stalled output holds its word; the middle stage and in_ch.ready back up
//  behind it.
`default_nettype none
module bank_switch_mapper_9bit_rom_core import bsm_pkg::*; #(
  parameter int RAM_BYTES = 131072
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bsm_in_if.sink    in_ch,
  bsm_out_if.source out_ch,
  bsm_cfg_if.sink   cfg_ch
);

  mem_req_t          req;
  stage_t            dec;
  logic              clr_busy;
  logic [DATA_W-1:0] ram_rdata;

  logic   in_acc;
  logic   s1_adv;
  logic   s1_valid_r;
  stage_t s1_r;

  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_fetch_r;
  logic [ROM_OFF_W-1:0] out_offset_r;
  logic                 out_rumble_r;

  // middle stage moves when the output register is free or draining
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !clr_busy && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;

  bsm_ctrl #(.RAM_BYTES(RAM_BYTES)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .in_acc  (in_acc),
    .op      (in_ch.op),
    .address (in_ch.address),
    .value   (in_ch.value),
    .req     (req),
    .res     (dec)
  );

  bsm_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .busy  (clr_busy),
    .rdata (ram_rdata)
  );

  // stage 1: RAM read in flight; rdata only changes on the next accepted read,
  // which can't happen before this word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || s1_adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= dec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r   <= s1_r.rd_ram ? ram_rdata : OPEN_BUS;
      out_fetch_r  <= s1_r.rom_fetch;
      out_offset_r <= s1_r.rom_offset;
      out_rumble_r <= s1_r.rumble;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_data_r;
  assign out_ch.rom_fetch  = out_fetch_r;
  assign out_ch.rom_offset = out_offset_r;
  assign out_ch.rumble_on  = out_rumble_r;

  // no words taken while the RAM sweep runs
  a_no_acc_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ch.ready)
    else $error("word accepted during RAM clear");

  // a held middle stage must block new words
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_acc)
    else $error("middle stage overrun");

  // an accepted word lands in the middle stage
  a_acc_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted word lost");

  // ROM fetches never carry RAM data
  a_fetch_open_bus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fetch_r) |-> (out_data_r == OPEN_BUS))
    else $error("ROM fetch with RAM data");

endmodule
`default_nettype wire
